/* design/assert_macros.svh */
// assertion macros shared by the dilated convolution engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define DCE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dce assertion failed");

// next-cycle implication, checked out of reset
`define DCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dce assertion failed");

`endif

/* design/dce_pkg.sv */
// shared types, codes and widths of the dilated convolution engine
`default_nettype none

package dce_pkg;

  // parameter defaults
  localparam int DefMaxHeight = 64;
  localparam int DefMaxWidth  = 64;
  localparam int DefMaxKernel = 7;
  localparam int DefPixelBits = 16;

  // fixed field widths
  localparam int ValueW   = 16;
  localparam int SumW     = 37;
  localparam int PosW     = 7;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 7;
  localparam int KernW    = 3;
  // padded-image coordinates and linear image addresses
  localparam int CoordW   = 11;
  localparam int LinW     = 2 * PosW;

  typedef enum logic [1:0] {
    OpLoadWeight = 2'd0,
    OpLoadPixel  = 2'd1,
    OpRequest    = 2'd2,
    OpNone       = 2'd3
  } op_e;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegHeight   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegWidth    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKernel   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStride   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPad      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDilation = 3'd5;

  typedef struct packed {
    logic load_w;
    logic load_p;
    logic req_fail;
    logic walk_start;
    logic walk_step;
    logic emit_ok;
  } cmd_t;

  typedef struct packed {
    logic can_run;
    logic tap_last;
  } sts_t;

endpackage

`default_nettype wire

/* design/dce_ctrl.sv */
// sequencer of the dilated convolution engine: load, tap walk, drain and emit
`default_nettype none

module dce_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic [1:0]          opcode_i,
  input  dce_pkg::sts_t       sts_i,
  output dce_pkg::cmd_t       cmd_o,
  output logic                busy
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StWalk   = 3'd1;
  localparam logic [2:0] StDrain1 = 3'd2;
  localparam logic [2:0] StDrain2 = 3'd3;
  localparam logic [2:0] StEmit   = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          case (opcode_i)
            dce_pkg::OpLoadWeight: cmd_o.load_w = 1'b1;
            dce_pkg::OpLoadPixel:  cmd_o.load_p = 1'b1;
            dce_pkg::OpRequest: begin
              if (sts_i.can_run) begin
                cmd_o.walk_start = 1'b1;
                state_d          = StWalk;
              end else begin
                cmd_o.req_fail = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      StWalk: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.tap_last) state_d = StDrain1;
      end
      // memory read and product stages empty out
      StDrain1: state_d = StDrain2;
      StDrain2: state_d = StEmit;
      StEmit: begin
        cmd_o.emit_ok = 1'b1;
        state_d       = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != StIdle);

endmodule

`default_nettype wire

/* design/dce_datapath.sv */
// datapath: configuration, image and weight memories, tap walker, mac and result register
`default_nettype none

module dce_datapath #(
  parameter int MAX_HEIGHT = dce_pkg::DefMaxHeight,
  parameter int MAX_WIDTH  = dce_pkg::DefMaxWidth,
  parameter int MAX_KERNEL = dce_pkg::DefMaxKernel,
  parameter int PIXEL_BITS = dce_pkg::DefPixelBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dce_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [dce_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic signed [dce_pkg::ValueW-1:0]   value_i,
  input  dce_pkg::cmd_t                       cmd_i,
  output dce_pkg::sts_t                       sts_o,
  output logic signed [dce_pkg::SumW-1:0]     conv_sum_o,
  output logic [dce_pkg::PosW-1:0]            out_row_o,
  output logic [dce_pkg::PosW-1:0]            out_col_o,
  output logic                                last_o,
  output logic                                status_o,
  output logic                                valid_o
);

  localparam int CoordW    = dce_pkg::CoordW;
  localparam int PosW      = dce_pkg::PosW;
  localparam int KernW     = dce_pkg::KernW;
  localparam int SumW      = dce_pkg::SumW;
  localparam int LinW      = dce_pkg::LinW;
  localparam int ValueBits = (PIXEL_BITS < dce_pkg::ValueW) ? PIXEL_BITS : dce_pkg::ValueW;
  localparam int ImgDepth  = MAX_HEIGHT * MAX_WIDTH;
  localparam int ImgAddrW  = (ImgDepth > 1) ? $clog2(ImgDepth) : 1;
  localparam int ImgCntW   = $clog2(ImgDepth + 1);
  localparam int WtDepth   = MAX_KERNEL * MAX_KERNEL;
  localparam int WtAddrW   = (WtDepth > 1) ? $clog2(WtDepth) : 1;
  localparam int WtCntW    = $clog2(WtDepth + 1);

  localparam logic [CoordW-1:0] MaxH = CoordW'(MAX_HEIGHT);
  localparam logic [CoordW-1:0] MaxW = CoordW'(MAX_WIDTH);
  localparam logic [KernW:0]    MaxK = (KernW + 1)'(MAX_KERNEL);

  // configuration registers
  logic [6:0]       height_q, width_q, stride_q;
  logic [KernW-1:0] ksize_q;
  logic [4:0]       pad_q;
  logic [5:0]       dil_q;
  logic             cfg_clear;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= 7'd1;
      width_q  <= 7'd1;
      ksize_q  <= 3'd1;
      stride_q <= 7'd1;
      pad_q    <= 5'd0;
      dil_q    <= 6'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dce_pkg::RegHeight:   height_q <= cfg_data_i;
        dce_pkg::RegWidth:    width_q  <= cfg_data_i;
        dce_pkg::RegKernel:   ksize_q  <= cfg_data_i[KernW-1:0];
        dce_pkg::RegStride:   stride_q <= cfg_data_i;
        dce_pkg::RegPad:      pad_q    <= cfg_data_i[4:0];
        dce_pkg::RegDilation: dil_q    <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // a write to a known register restarts the job
  assign cfg_clear = cfg_we_i && (cfg_idx_i <= dce_pkg::RegDilation);

  // effective geometry
  logic [6:0]        hc, wc, st;
  logic [5:0]        dl;
  logic [KernW-1:0]  kc;
  logic [5:0]        kk;
  logic [LinW-1:0]   hw;
  logic [CoordW-1:0] ph, pw, eff, pad_c;

  always_comb begin
    hc = (height_q == 7'd0) ? 7'd1 :
         ((CoordW'(height_q) > MaxH) ? MaxH[6:0] : height_q);
    wc = (width_q == 7'd0) ? 7'd1 :
         ((CoordW'(width_q) > MaxW) ? MaxW[6:0] : width_q);
    kc = (ksize_q == 3'd0) ? 3'd1 :
         (({1'b0, ksize_q} > MaxK) ? MaxK[KernW-1:0] : ksize_q);
    st = (stride_q == 7'd0) ? 7'd1 : stride_q;
    dl = (dil_q == 6'd0) ? 6'd1 : dil_q;
    kk = 6'(kc) * 6'(kc);
    hw = LinW'(hc) * LinW'(wc);
    pad_c = CoordW'(pad_q);
    ph  = CoordW'(hc) + (pad_c << 1);
    pw  = CoordW'(wc) + (pad_c << 1);
    eff = (CoordW'(kc) - CoordW'(1)) * CoordW'(dl) + CoordW'(1);
  end

  // job state: load counts and output position
  logic [WtCntW-1:0]  wcnt_q;
  logic [ImgCntW-1:0] pcnt_q;
  logic [PosW-1:0]    row_q, col_q;
  logic [CoordW-1:0]  orow_q, ocol_q;
  logic               done_q;
  logic               wt_we, img_we;
  logic               geom_ok, row_fits, col_fits, row_last, col_last;

  assign wt_we  = cmd_i.load_w && (wcnt_q < WtCntW'(kk));
  assign img_we = cmd_i.load_p && (pcnt_q < ImgCntW'(hw));

  assign geom_ok  = (eff <= ph) && (eff <= pw);
  assign row_fits = (orow_q + eff) <= ph;
  assign col_fits = (ocol_q + eff) <= pw;
  assign row_last = (orow_q + CoordW'(st) + eff) > ph;
  assign col_last = (ocol_q + CoordW'(st) + eff) > pw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcnt_q <= '0;
      pcnt_q <= '0;
      row_q  <= '0;
      col_q  <= '0;
      orow_q <= '0;
      ocol_q <= '0;
      done_q <= 1'b0;
    end else if (cfg_clear) begin
      wcnt_q <= '0;
      pcnt_q <= '0;
      row_q  <= '0;
      col_q  <= '0;
      orow_q <= '0;
      ocol_q <= '0;
      done_q <= 1'b0;
    end else begin
      if (wt_we)  wcnt_q <= wcnt_q + WtCntW'(1);
      if (img_we) pcnt_q <= pcnt_q + ImgCntW'(1);
      if (cmd_i.req_fail) done_q <= 1'b1;
      if (cmd_i.emit_ok) begin
        if (row_last && col_last) begin
          done_q <= 1'b1;
        end else if (col_last) begin
          col_q  <= '0;
          ocol_q <= '0;
          row_q  <= row_q + PosW'(1);
          orow_q <= orow_q + CoordW'(st);
        end else begin
          col_q  <= col_q + PosW'(1);
          ocol_q <= ocol_q + CoordW'(st);
        end
      end
    end
  end

  // tap walker: raster order over the kernel, padded coordinates stepped by dilation
  logic [KernW-1:0]   u_q, v_q;
  logic [CoordW-1:0]  xa_q, ya_q;
  logic [WtAddrW-1:0] wi_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_start) begin
      u_q  <= '0;
      v_q  <= '0;
      xa_q <= orow_q;
      ya_q <= ocol_q;
      wi_q <= '0;
    end else if (cmd_i.walk_step) begin
      wi_q <= wi_q + WtAddrW'(1);
      if (v_q == kc - 3'd1) begin
        v_q  <= '0;
        ya_q <= ocol_q;
        u_q  <= u_q + 3'd1;
        xa_q <= xa_q + CoordW'(dl);
      end else begin
        v_q  <= v_q + 3'd1;
        ya_q <= ya_q + CoordW'(dl);
      end
    end
  end

  assign sts_o.tap_last = (u_q == kc - 3'd1) && (v_q == kc - 3'd1);
  assign sts_o.can_run  = geom_ok && !done_q && row_fits && col_fits;

  // tap position inside the image proper, and its linear address
  logic [CoordW-1:0]   xm, ym;
  logic                tap_in;
  logic [LinW-1:0]     lin;
  logic [ImgAddrW-1:0] img_raddr;

  always_comb begin
    xm = xa_q - pad_c;
    ym = ya_q - pad_c;
    tap_in = (xa_q >= pad_c) && (ya_q >= pad_c) &&
             (xm < CoordW'(hc)) && (ym < CoordW'(wc));
    lin = LinW'(xm[PosW-1:0]) * LinW'(wc) + LinW'(ym[PosW-1:0]);
    img_raddr = ImgAddrW'(lin);
  end

  // memories with registered reads
  logic signed [ValueBits-1:0] img_mem_q [ImgDepth];
  logic signed [ValueBits-1:0] wt_mem_q [WtDepth];
  logic signed [ValueBits-1:0] pix_rd_q, wt_rd_q;

  always_ff @(posedge clk_i) begin
    if (img_we) img_mem_q[pcnt_q[ImgAddrW-1:0]] <= value_i[ValueBits-1:0];
    pix_rd_q <= img_mem_q[img_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wt_we) wt_mem_q[wcnt_q[WtAddrW-1:0]] <= value_i[ValueBits-1:0];
    wt_rd_q <= wt_mem_q[wi_q];
  end

  // multiply and accumulate; taps in the padding contribute zero
  logic                          tap_ok_q;
  logic signed [2*ValueBits-1:0] mult, prod_q;
  logic signed [SumW-1:0]        acc_q;

  assign mult = pix_rd_q * wt_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_ok_q <= 1'b0;
    end else begin
      tap_ok_q <= cmd_i.walk_step && tap_in;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= tap_ok_q ? mult : '0;
    if (cmd_i.walk_start) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_q + SumW'(prod_q);
    end
  end

  // result register
  logic                   valid_q;
  logic signed [SumW-1:0] res_sum_q;
  logic [PosW-1:0]        res_row_q, res_col_q;
  logic                   res_last_q, res_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.req_fail || cmd_i.emit_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_fail) begin
      res_sum_q    <= '0;
      res_row_q    <= '0;
      res_col_q    <= '0;
      res_last_q   <= 1'b0;
      res_status_q <= 1'b1;
    end else if (cmd_i.emit_ok) begin
      res_sum_q    <= acc_q;
      res_row_q    <= row_q;
      res_col_q    <= col_q;
      res_last_q   <= row_last && col_last;
      res_status_q <= 1'b0;
    end
  end

  assign valid_o    = valid_q;
  assign conv_sum_o = res_sum_q;
  assign out_row_o  = res_row_q;
  assign out_col_o  = res_col_q;
  assign last_o     = res_last_q;
  assign status_o   = res_status_q;

endmodule

`default_nettype wire

/* design/dilated_conv2d_engine.sv */
// Dilated 2D convolution engine. Weight and pixel loads are taken one per cycle while
// busy is low and give no result. A request (start with opcode 2 while busy is low)
// walks the k by k taps through one multiply-accumulate unit, one tap per cycle, fed by
// the single read port of the image memory: busy stays high through the walk, the
// drain states and the emit state, the result strobe valid_o is registered from the
// emit state, and the next transaction is taken only once busy is low again. A request
// that finds no output left (or a kernel larger than the padded image) answers with
// status 1 on the next cycle. valid_o is high for exactly one cycle per request and
// cannot be held off; writes to the known registers restart the job.
`default_nettype none
`include "assert_macros.svh"

module dilated_conv2d_engine #(
  parameter int MAX_HEIGHT = dce_pkg::DefMaxHeight,
  parameter int MAX_WIDTH  = dce_pkg::DefMaxWidth,
  parameter int MAX_KERNEL = dce_pkg::DefMaxKernel,
  parameter int PIXEL_BITS = dce_pkg::DefPixelBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          opcode_i,
  input  logic signed [dce_pkg::ValueW-1:0]   value_i,
  input  logic                                cfg_we_i,
  input  logic [dce_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [dce_pkg::CfgDataW-1:0]        cfg_data_i,
  output logic                                valid_o,
  output logic signed [dce_pkg::SumW-1:0]     conv_sum_o,
  output logic [dce_pkg::PosW-1:0]            out_row_o,
  output logic [dce_pkg::PosW-1:0]            out_col_o,
  output logic                                last_o,
  output logic                                status_o
);

  dce_pkg::cmd_t dp_cmd;
  dce_pkg::sts_t dp_sts;

  dce_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (opcode_i),
    .sts_i    (dp_sts),
    .cmd_o    (dp_cmd),
    .busy     (busy)
  );

  dce_datapath #(
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_KERNEL (MAX_KERNEL),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .value_i    (value_i),
    .cmd_i      (dp_cmd),
    .sts_o      (dp_sts),
    .conv_sum_o (conv_sum_o),
    .out_row_o  (out_row_o),
    .out_col_o  (out_col_o),
    .last_o     (last_o),
    .status_o   (status_o),
    .valid_o    (valid_o)
  );

  // a result only shows once the walk has ended
  `DCE_ASSERT_IMPL(a_no_result_while_busy, clk_i, rst_ni, valid_o, !busy)

  // an empty answer carries no sum and no last mark
  `DCE_ASSERT_IMPL(a_fail_is_clean, clk_i, rst_ni, valid_o && status_o,
                   (conv_sum_o == '0) && !last_o)

  // every request either answers next cycle or starts a walk
  `DCE_ASSERT_NEXT(a_request_answered, clk_i, rst_ni,
                   start && !busy && (opcode_i == dce_pkg::OpRequest), valid_o || busy)

  // taps are only issued while the sequencer is busy
  `DCE_ASSERT_IMPL(a_step_when_busy, clk_i, rst_ni, dp_cmd.walk_step, busy)

endmodule

`default_nettype wire

/* tb/dilated_conv2d_engine_tb.sv */
// self-checking testbench for the dilated 2d convolution engine
`timescale 1ns / 1ps

module dilated_conv2d_engine_tb;

  localparam int DrainCycles = 64;    // longest request walks 7x7 taps, then drains and emits
  localparam int StallLimit  = 2000;
  localparam int ItemTarget  = 1750;
  localparam int MaxPixels   = 640;   // keeps most jobs short
  localparam logic [dce_pkg::CfgIdxW-1:0] RegUnused = 3'd6;

  typedef struct packed {
    logic signed [dce_pkg::SumW-1:0] total;
    logic [dce_pkg::PosW-1:0]        row;
    logic [dce_pkg::PosW-1:0]        col;
    logic                            last;
    logic                            status;
  } conv_res_t;

  typedef struct packed {
    logic                          cfg;
    logic [dce_pkg::CfgIdxW-1:0]   idx;
    logic [dce_pkg::CfgDataW-1:0]  data;
    dce_pkg::op_e                  op;
    logic [dce_pkg::ValueW-1:0]    val;
    logic                          typed;
    conv_res_t                     res;
  } step_t;

  localparam conv_res_t NoOutput =
    '{total: '0, row: '0, col: '0, last: 1'b0, status: 1'b1};
  localparam conv_res_t MinSquared =
    '{total: 37'sd1073741824, row: '0, col: '0, last: 1'b1, status: 1'b0};

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                start = 1'b0;
  logic                                busy;
  logic [1:0]                          opcode_i = dce_pkg::OpLoadWeight;
  logic signed [dce_pkg::ValueW-1:0]   value_i = '0;
  logic                                cfg_we_i = 1'b0;
  logic [dce_pkg::CfgIdxW-1:0]         cfg_idx_i = dce_pkg::RegHeight;
  logic [dce_pkg::CfgDataW-1:0]        cfg_data_i = '0;
  logic                                valid_o;
  logic signed [dce_pkg::SumW-1:0]     conv_sum_o;
  logic [dce_pkg::PosW-1:0]            out_row_o;
  logic [dce_pkg::PosW-1:0]            out_col_o;
  logic                                last_o;
  logic                                status_o;

  dilated_conv2d_engine i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .opcode_i   (opcode_i),
    .value_i    (value_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .valid_o    (valid_o),
    .conv_sum_o (conv_sum_o),
    .out_row_o  (out_row_o),
    .out_col_o  (out_col_o),
    .last_o     (last_o),
    .status_o   (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // engine image: stores, load counters, output position, effective geometry
  logic signed [dce_pkg::ValueW-1:0] pix_mem [4096];
  logic signed [dce_pkg::ValueW-1:0] wt_mem  [49];
  bit pix_set [4096];
  bit wt_set  [49];
  int wt_cnt, pix_cnt, nxt_row, nxt_col;
  bit all_done;
  int g_h = 1, g_w = 1, g_k = 1, g_st = 1, g_p = 0, g_dl = 1;

  conv_res_t   due_q [$];
  int unsigned bad_results;
  int unsigned idle_pct = 34;
  int unsigned items_sent;

  function automatic int clamp_dim(logic [dce_pkg::CfgDataW-1:0] v, int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : int'(v);
  endfunction

  function automatic void apply_reg(logic [dce_pkg::CfgIdxW-1:0] idx,
                                    logic [dce_pkg::CfgDataW-1:0] v);
    case (idx)
      dce_pkg::RegHeight:   g_h = clamp_dim(v, dce_pkg::DefMaxHeight);
      dce_pkg::RegWidth:    g_w = clamp_dim(v, dce_pkg::DefMaxWidth);
      dce_pkg::RegKernel:   g_k = (v[2:0] == 0) ? 1 : int'(v[2:0]);
      dce_pkg::RegStride:   g_st = (v == 0) ? 1 : int'(v);
      dce_pkg::RegPad:      g_p = int'(v[4:0]);
      dce_pkg::RegDilation: g_dl = (v[5:0] == 0) ? 1 : int'(v[5:0]);
      default:              return;
    endcase
    // every write to a known register starts a new job
    wt_cnt = 0;
    pix_cnt = 0;
    nxt_row = 0;
    nxt_col = 0;
    all_done = 1'b0;
  endfunction

  // output grid size; returns 1 when the next request yields a real output
  function automatic bit next_window(output int oh, output int ow);
    int ph, pw, span;
    ph = g_h + 2 * g_p;
    pw = g_w + 2 * g_p;
    span = (g_k - 1) * g_dl + 1;
    oh = 0;
    ow = 0;
    if (span > ph || span > pw) return 1'b0;
    oh = (ph - span) / g_st + 1;
    ow = (pw - span) / g_st + 1;
    return !all_done && nxt_row < oh && nxt_col < ow;
  endfunction

  // window at the current position; ready is low if a tap hits an unwritten entry
  function automatic longint window_sum(output bit ready);
    longint acc;
    int x, y, u, v;
    acc = 0;
    ready = 1'b1;
    for (u = 0; u < g_k; u++) begin
      for (v = 0; v < g_k; v++) begin
        x = nxt_row * g_st + u * g_dl - g_p;
        y = nxt_col * g_st + v * g_dl - g_p;
        if (x >= 0 && x < g_h && y >= 0 && y < g_w) begin
          if (!pix_set[x * g_w + y] || !wt_set[u * g_k + v]) ready = 1'b0;
          acc += longint'(pix_mem[x * g_w + y]) * longint'(wt_mem[u * g_k + v]);
        end
      end
    end
    return acc;
  endfunction

  function automatic bit request_ok();
    int oh, ow;
    bit ready;
    if (!next_window(oh, ow)) return 1'b1;
    void'(window_sum(ready));
    return ready;
  endfunction

  // advances the engine image by one transaction; returns 1 if a result follows
  function automatic bit conv_predict(dce_pkg::op_e op, logic [dce_pkg::ValueW-1:0] val,
                                      output conv_res_t res);
    int oh, ow;
    bit ready;
    longint acc;
    res = NoOutput;
    case (op)
      dce_pkg::OpLoadWeight: begin
        if (wt_cnt < g_k * g_k) begin
          wt_mem[wt_cnt] = val;
          wt_set[wt_cnt] = 1'b1;
          wt_cnt++;
        end
        return 1'b0;
      end
      dce_pkg::OpLoadPixel: begin
        if (pix_cnt < g_h * g_w) begin
          pix_mem[pix_cnt] = val;
          pix_set[pix_cnt] = 1'b1;
          pix_cnt++;
        end
        return 1'b0;
      end
      dce_pkg::OpRequest: begin
        if (!next_window(oh, ow)) begin
          all_done = 1'b1;
          return 1'b1;
        end
        acc = window_sum(ready);
        res.total  = acc[dce_pkg::SumW-1:0];
        res.row    = dce_pkg::PosW'(nxt_row);
        res.col    = dce_pkg::PosW'(nxt_col);
        res.last   = (nxt_row == oh - 1) && (nxt_col == ow - 1);
        res.status = 1'b0;
        if (res.last) begin
          all_done = 1'b1;
        end else if (nxt_col + 1 >= ow) begin
          nxt_col = 0;
          nxt_row++;
        end else begin
          nxt_col++;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [dce_pkg::ValueW-1:0] rand_value();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return dce_pkg::ValueW'($urandom);
    endcase
  endfunction

  function automatic logic [dce_pkg::CfgDataW-1:0] pick_reg(logic [dce_pkg::CfgIdxW-1:0] idx);
    int unsigned sel;
    sel = $urandom_range(99);
    case (idx)
      dce_pkg::RegHeight, dce_pkg::RegWidth: begin
        if (sel < 70) return dce_pkg::CfgDataW'($urandom_range(8, 1));
        if (sel < 85) return dce_pkg::CfgDataW'($urandom_range(16, 9));
        if (sel < 92) return 7'd64;
        if (sel < 97) return dce_pkg::CfgDataW'($urandom_range(127, 65));
        return 7'd0;
      end
      dce_pkg::RegStride: begin
        if (sel < 60) return 7'd1;
        if (sel < 85) return dce_pkg::CfgDataW'($urandom_range(4, 2));
        if (sel < 95) return dce_pkg::CfgDataW'($urandom_range(63, 5));
        case ($urandom_range(2))
          0:       return 7'd0;
          1:       return 7'd64;
          default: return 7'd127;
        endcase
      end
      dce_pkg::RegPad: begin
        if (sel < 60) return dce_pkg::CfgDataW'($urandom_range(2));
        if (sel < 90) return dce_pkg::CfgDataW'($urandom_range(31, 3));
        return dce_pkg::CfgDataW'($urandom);
      end
      dce_pkg::RegDilation: begin
        if (sel < 60) return 7'd1;
        if (sel < 85) return dce_pkg::CfgDataW'($urandom_range(4, 2));
        if (sel < 95) return dce_pkg::CfgDataW'($urandom_range(32, 5));
        return dce_pkg::CfgDataW'($urandom);
      end
      default: return dce_pkg::CfgDataW'($urandom);
    endcase
  endfunction

  // engine idle and nothing outstanding before touching registers
  task automatic settle();
    start <= 1'b0;
    cfg_we_i <= 1'b0;
    while (due_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [dce_pkg::CfgIdxW-1:0] idx,
                           logic [dce_pkg::CfgDataW-1:0] data);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    apply_reg(idx, data);
  endtask

  // start stays high across back-to-back transactions
  task automatic send_item(dce_pkg::op_e op, logic [dce_pkg::ValueW-1:0] val, bit typed,
                           conv_res_t fixed);
    conv_res_t res;
    cfg_we_i <= 1'b0;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start    <= 1'b1;
    opcode_i <= op;
    value_i  <= val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (conv_predict(op, val, res)) due_q.push_back(typed ? fixed : res);
  endtask

  task automatic feed(dce_pkg::op_e op);
    if (op == dce_pkg::OpRequest && !request_ok()) begin
      if ($urandom_range(1) != 0) op = dce_pkg::OpLoadPixel;
      else op = dce_pkg::OpLoadWeight;
    end
    send_item(op, rand_value(), 1'b0, NoOutput);
    if (op != dce_pkg::OpNone) items_sent++;
    idle_pct = (items_sent >= 700 && items_sent < 1000) ? 0 : 34;
  endtask

  task automatic note_mismatch(string what, conv_res_t want, conv_res_t got);
    if (bad_results < 10)
      $display({"%s: expected total=%0d row=%0d col=%0d last=%0b status=%0b,",
                " got total=%0d row=%0d col=%0d last=%0b status=%0b"},
               what, $signed(want.total), want.row, want.col, want.last, want.status,
               $signed(got.total), got.row, got.col, got.last, got.status);
    bad_results++;
  endtask

  always @(posedge clk_i) begin
    conv_res_t got, want;
    if (rst_ni && valid_o) begin
      got.total  = conv_sum_o;
      got.row    = out_row_o;
      got.col    = out_col_o;
      got.last   = last_o;
      got.status = status_o;
      if (due_q.size() == 0) begin
        note_mismatch("result with nothing pending", '0, got);
      end else begin
        want = due_q.pop_front();
        if (got.total !== want.total || got.row !== want.row || got.col !== want.col ||
            got.last !== want.last || got.status !== want.status)
          note_mismatch("result mismatch", want, got);
      end
    end
  end

  // watchdog: ends the run when no transaction of any kind happens for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((start && !busy) || valid_o || cfg_we_i) quiet = 0;
      else quiet++;
    end
    $display("dilated_conv2d_engine_tb: FAIL");
    $finish;
  end

  step_t dir_tab [31] = '{
    '{1'b0, dce_pkg::RegHeight,   7'd0, dce_pkg::OpLoadWeight, 16'h8000, 1'b0, NoOutput},
    '{1'b0, dce_pkg::RegHeight,   7'd0, dce_pkg::OpLoadPixel,  16'h8000, 1'b0, NoOutput},
    '{1'b0, dce_pkg::RegHeight,   7'd0, dce_pkg::OpRequest,    16'h0000, 1'b1, MinSquared},
    // outputs exhausted
    '{1'b0, dce_pkg::RegHeight,   7'd0, dce_pkg::OpRequest,    16'hFFFF, 1'b1, NoOutput},
    '{1'b0, dce_pkg::RegHeight,   7'd0, dce_pkg::OpNone,       16'hFFFF, 1'b0, NoOutput},
    // kernel wider than the image
    '{1'b1, dce_pkg::RegKernel,   7'd7, dce_pkg::OpNone,       16'h0000, 1'b0, NoOutput},
    '{1'b0, dce_pkg::RegHeight,   7'd0, dce_pkg::OpRequest,    16'h0000, 1'b1, NoOutput},
    '{1'b1, dce_pkg::RegKernel,   7'd2, dce_pkg::OpNone,       16'h0000, 1'b0, NoOutput},
    '{1'b1, dce_pkg::RegHeight,   7'd2, dce_pkg::OpNone,       16'h0000, 1'b0, NoOutput},
    '{1'b1, dce_pkg::RegWidth,    7'd2, dce_pkg::OpNone,       16'h0000, 1'b0, NoOutput},
    '{1'b0, dce_pkg::RegHeight,   7'd0, dce_pkg::OpLoadWeight, 16'h7FFF, 1'b0, NoOutput},
    '{1'b0, dce_pkg::RegHeight,   7'd0, dce_pkg::OpLoadWeight, 16'h8000, 1'b0, NoOutput},
    '{1'b0, dce_pkg::RegHeight,   7'd0, dce_pkg::OpLoadWeight, 16'h7FFF, 1'b0, NoOutput},
    '{1'b0, dce_pkg::RegHeight,   7'd0, dce_pkg::OpLoadWeight, 16'hFFFF, 1'b0, NoOutput},
    // extra weight and extra pixel are dropped
    '{1'b0, dce_pkg::RegHeight,   7'd0, dce_pkg::OpLoadWeight, 16'h1234, 1'b0, NoOutput},
    '{1'b0, dce_pkg::RegHeight,   7'd0, dce_pkg::OpLoadPixel,  16'h7FFF, 1'b0, NoOutput},
    '{1'b0, dce_pkg::RegHeight,   7'd0, dce_pkg::OpLoadPixel,  16'h7FFF, 1'b0, NoOutput},
    '{1'b0, dce_pkg::RegHeight,   7'd0, dce_pkg::OpLoadPixel,  16'h8000, 1'b0, NoOutput},
    '{1'b0, dce_pkg::RegHeight,   7'd0, dce_pkg::OpLoadPixel,  16'h8000, 1'b0, NoOutput},
    '{1'b0, dce_pkg::RegHeight,   7'd0, dce_pkg::OpLoadPixel,  16'h0001, 1'b0, NoOutput},
    '{1'b0, dce_pkg::RegHeight,   7'd0, dce_pkg::OpRequest,    16'h0000, 1'b0, NoOutput},
    '{1'b0, dce_pkg::RegHeight,   7'd0, dce_pkg::OpRequest,    16'h0000, 1'b1, NoOutput},
    // padding, dilation and stride on the stored image
    '{1'b1, dce_pkg::RegPad,      7'd1, dce_pkg::OpNone,       16'h0000, 1'b0, NoOutput},
    '{1'b0, dce_pkg::RegHeight,   7'd0, dce_pkg::OpRequest,    16'h0000, 1'b0, NoOutput},
    '{1'b0, dce_pkg::RegHeight,   7'd0, dce_pkg::OpRequest,    16'h0000, 1'b0, NoOutput},
    '{1'b1, dce_pkg::RegDilation, 7'd2, dce_pkg::OpNone,       16'h0000, 1'b0, NoOutput},
    '{1'b0, dce_pkg::RegHeight,   7'd0, dce_pkg::OpRequest,    16'h0000, 1'b0, NoOutput},
    '{1'b1, dce_pkg::RegStride,   7'd3, dce_pkg::OpNone,       16'h0000, 1'b0, NoOutput},
    '{1'b0, dce_pkg::RegHeight,   7'd0, dce_pkg::OpRequest,    16'h0000, 1'b0, NoOutput},
    '{1'b0, dce_pkg::RegHeight,   7'd0, dce_pkg::OpRequest,    16'h0000, 1'b1, NoOutput},
    '{1'b0, dce_pkg::RegHeight,   7'd0, dce_pkg::OpNone,       16'h5A5A, 1'b0, NoOutput}
  };

  initial begin : stim
    logic [dce_pkg::CfgDataW-1:0] nv [6];
    bit wr [6];
    dce_pkg::op_e plan [$];
    int phase, eh, ew, oh, ow, n_r;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg) write_reg(dir_tab[i].idx, dir_tab[i].data);
      else send_item(dir_tab[i].op, dir_tab[i].val, dir_tab[i].typed, dir_tab[i].res);
    end

    phase = 0;
    while (items_sent < ItemTarget) begin
      for (int i = 0; i < 6; i++) begin
        wr[i] = (phase == 0) || ($urandom_range(99) < 60);
        nv[i] = pick_reg(dce_pkg::CfgIdxW'(i));
      end
      // corner settings first: largest image side and kernel, widest spacing, zero values
      if (phase < 4) begin
        foreach (wr[i]) wr[i] = 1'b1;
        case (phase)
          0: begin
            nv[dce_pkg::RegHeight]   = 7'd64;
            nv[dce_pkg::RegWidth]    = 7'd8;
            nv[dce_pkg::RegKernel]   = 7'd7;
            nv[dce_pkg::RegStride]   = 7'd1;
            nv[dce_pkg::RegPad]      = 7'd0;
            nv[dce_pkg::RegDilation] = 7'd1;
          end
          1: begin
            nv[dce_pkg::RegHeight]   = 7'd2;
            nv[dce_pkg::RegWidth]    = 7'd64;
            nv[dce_pkg::RegKernel]   = 7'd1;
            nv[dce_pkg::RegStride]   = 7'd64;
            nv[dce_pkg::RegPad]      = 7'd31;
            nv[dce_pkg::RegDilation] = 7'd32;
          end
          2: begin
            nv[dce_pkg::RegHeight]   = 7'd3;
            nv[dce_pkg::RegWidth]    = 7'd3;
            nv[dce_pkg::RegKernel]   = 7'd7;
            nv[dce_pkg::RegStride]   = 7'd127;
            nv[dce_pkg::RegPad]      = 7'd31;
            nv[dce_pkg::RegDilation] = 7'd32;
          end
          default: begin
            nv[dce_pkg::RegHeight]   = 7'd0;
            nv[dce_pkg::RegWidth]    = 7'd127;
            nv[dce_pkg::RegKernel]   = 7'd0;
            nv[dce_pkg::RegStride]   = 7'd0;
            nv[dce_pkg::RegPad]      = 7'h60;
            nv[dce_pkg::RegDilation] = 7'd0;
          end
        endcase
      end
      eh = wr[dce_pkg::RegHeight] ?
           clamp_dim(nv[dce_pkg::RegHeight], dce_pkg::DefMaxHeight) : g_h;
      ew = wr[dce_pkg::RegWidth] ?
           clamp_dim(nv[dce_pkg::RegWidth], dce_pkg::DefMaxWidth) : g_w;
      if (eh * ew > MaxPixels) begin
        nv[dce_pkg::RegWidth] = dce_pkg::CfgDataW'($urandom_range(8, 1));
        wr[dce_pkg::RegWidth] = 1'b1;
      end
      for (int i = 0; i < 6; i++)
        if (wr[i]) write_reg(dce_pkg::CfgIdxW'(i), nv[i]);
      if ($urandom_range(9) == 0)
        write_reg(RegUnused | dce_pkg::CfgIdxW'($urandom_range(1)),
                  dce_pkg::CfgDataW'($urandom));

      plan.delete();
      if (phase < 4 || $urandom_range(99) < 80) begin
        // well-formed job: kernel, image, then a run of output requests
        void'(next_window(oh, ow));
        n_r = (oh * ow <= 30) ? oh * ow + $urandom_range(2) : $urandom_range(30, 5);
        if (n_r == 0) n_r = $urandom_range(3, 1);
        repeat (g_k * g_k + (($urandom_range(9) == 0) ? $urandom_range(2, 1) : 0))
          plan.push_back(dce_pkg::OpLoadWeight);
        repeat (g_h * g_w + (($urandom_range(9) == 0) ? $urandom_range(2, 1) : 0))
          plan.push_back(dce_pkg::OpLoadPixel);
        repeat (n_r) plan.push_back(dce_pkg::OpRequest);
      end else begin
        repeat ($urandom_range(40, 5)) plan.push_back(dce_pkg::op_e'($urandom_range(3)));
      end
      foreach (plan[i]) begin
        if ($urandom_range(99) < 4) feed(dce_pkg::op_e'($urandom_range(3)));
        feed(plan[i]);
      end
      phase++;
    end

    start <= 1'b0;
    while (due_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (bad_results == 0 && due_q.size() == 0)
      $display("dilated_conv2d_engine_tb: PASS");
    else
      $display("dilated_conv2d_engine_tb: FAIL");
    $finish;
  end

endmodule

/* dilated_conv2d_engine.f */
+incdir+design
design/dce_pkg.sv
design/dce_ctrl.sv
design/dce_datapath.sv
design/dilated_conv2d_engine.sv
tb/dilated_conv2d_engine_tb.sv
